### rtl/z2hb_pkg.sv
// Package for the Z2 heatbath link update block: types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
package z2hb_pkg;
    localparam int unsigned LatticeSideDefault = 8;
    localparam int unsigned ReplicasDefault    = 16;
    localparam int unsigned NumThresh          = 7;
    localparam int unsigned AccW               = 18;
    localparam int unsigned CfgAddrW           = 5;

    // Byte addresses of the threshold registers.
    typedef enum logic [CfgAddrW-1:0] {
        REG_TH_M6   = 5'd0,
        REG_TH_M4   = 5'd4,
        REG_TH_M2   = 5'd8,
        REG_TH_ZERO = 5'd12,
        REG_TH_P2   = 5'd16,
        REG_TH_P4   = 5'd20,
        REG_TH_P6   = 5'd24
    } reg_addr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;      // capture the input item
        logic       rd;        // issue a link read
        logic [4:0] rd_step;   // which of the eighteen neighbor reads
        logic       acc_link;  // fold the returned link into the staple
        logic [4:0] acc_step;  // which read the returned data belongs to
        logic       decide;    // compare, write the link, update the action
        logic       clear_go;  // clear one memory row
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
    } dp_stat_t;
endpackage

### rtl/z2hb_ctrl.sv
// Controller state machine: sequences memory clear, neighbor reads and the
// decision for one link. Depends on z2hb_pkg.
`timescale 1ns / 1ps
module z2hb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_free,
    input  z2hb_pkg::dp_stat_t  stat,
    output logic                in_ready,
    output z2hb_pkg::dp_cmd_t   cmd
);
    import z2hb_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_DECIDE} state_t;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       pend_reg, pend_next;
    logic [4:0] pstep_reg, pstep_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pend_next  = 1'b0;
        pstep_next = step_reg;
        cmd        = '0;
        cmd.rd_step  = step_reg;
        cmd.acc_step = pstep_reg;
        cmd.acc_link = pend_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_go = 1'b1;
                if (stat.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd    = 1'b1;
                pend_next = 1'b1;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd17)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                // Wait for the last read to land and for the output to drain.
                if (!pend_reg && out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg  <= '0;
            pend_reg  <= 1'b0;
            pstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pend_reg  <= pend_next;
            pstep_reg <= pstep_next;
        end
    end

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> step_reg <= 5'd17)
        else $error("read step out of range");
    a_decide_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> !cmd.decide)
        else $error("two decisions in a row");
endmodule

### rtl/z2hb_datapath.sv
// Datapath: link memory, neighbor address generation, staple sum, threshold
// compare and action accumulator. Depends on z2hb_pkg.
`timescale 1ns / 1ps
module z2hb_datapath #(
    parameter int unsigned LATTICE_SIDE = z2hb_pkg::LatticeSideDefault,
    parameter int unsigned REPLICAS     = z2hb_pkg::ReplicasDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  z2hb_pkg::dp_cmd_t    cmd,
    output z2hb_pkg::dp_stat_t   stat,
    input  logic [3:0]           in_replica,
    input  logic [2:0]           in_coord [4],
    input  logic [1:0]           in_dir,
    input  logic [31:0]          in_rnd,
    input  logic                 in_sweep,
    input  logic [31:0]          thresh [7],
    output logic                 res_link,
    output logic signed [3:0]    res_staple,
    output logic signed [17:0]   res_action
);
    import z2hb_pkg::*;

    localparam int unsigned CW    = (LATTICE_SIDE > 1) ? $clog2(LATTICE_SIDE) : 1;
    localparam int unsigned RW    = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
    localparam int unsigned SITEW = 4 * CW;
    localparam int unsigned LW    = RW + SITEW + 2;
    localparam int unsigned DEPTH = REPLICAS * (LATTICE_SIDE ** 4) * 4;
    localparam int unsigned ROWW  = RW + SITEW;
    // Rows are addressed by the concatenated replica and coordinates, so the
    // memory spans the full power-of-two address range.
    localparam int unsigned ROWS  = 1 << ROWW;
    localparam logic [CW-1:0] SideM1 = CW'(LATTICE_SIDE - 1);

    // One row holds the four link directions of a site; 1 means minus.
    logic [3:0]        mem [ROWS];
    logic [3:0]        rd_data_reg;
    logic [1:0]        rd_lane_reg;
    logic [ROWW-1:0]   clr_reg;
    logic              clr_done_reg;

    logic [RW-1:0]     rep_reg;
    logic [CW-1:0]     site_reg [4];
    logic [1:0]        dir_reg;
    logic [31:0]       rnd_reg;
    logic              sweep_reg;
    logic              prod_reg;      // running staple product, 1 means minus
    logic signed [3:0] sum_reg;
    logic signed [AccW-1:0] acc_reg;

    function automatic logic [CW-1:0] wrap_mod(input logic [2:0] v);
        logic [3:0] r;
        r = {1'b0, v};
        for (int i = 0; i < 4; i++)
            if (r >= 4'(LATTICE_SIDE))
                r = r - 4'(LATTICE_SIDE);
        return r[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] c_up(input logic [CW-1:0] v);
        return (v == SideM1) ? '0 : v + CW'(1);
    endfunction

    function automatic logic [CW-1:0] c_dn(input logic [CW-1:0] v);
        return (v == '0) ? SideM1 : v - CW'(1);
    endfunction

    function automatic logic in_rnd_cmp(input logic [31:0] a, input logic [31:0] b);
        return a < b;
    endfunction

    // Decode the read step: perp index (three perp dirs), six links per perp.
    logic [1:0]    perp;
    logic [2:0]    sub;
    logic [1:0]    pidx;
    logic [CW-1:0] y [4];
    logic [1:0]    ydir;
    logic [ROWW-1:0] rd_row;
    logic [4:0]    rstep;

    always_comb
    begin
        rstep = cmd.rd_step;
        pidx  = 2'd0;
        sub   = 3'd0;
        for (int i = 0; i < 3; i++)
            if (rstep >= 5'(6 * i) && rstep < 5'(6 * i + 6))
            begin
                pidx = 2'(i);
                sub  = 3'(rstep - 5'(6 * i));
            end
        perp = (2'(pidx) >= dir_reg) ? pidx + 2'd1 : pidx;
        for (int k = 0; k < 4; k++)
            y[k] = site_reg[k];
        ydir = perp;
        unique case (sub)
            3'd0: begin y[perp] = c_dn(site_reg[perp]); ydir = perp; end
            3'd1: begin y[perp] = c_dn(site_reg[perp]); ydir = dir_reg; end
            3'd2:
            begin
                y[perp] = c_dn(site_reg[perp]);
                y[dir_reg] = c_up(site_reg[dir_reg]);
                ydir = perp;
            end
            3'd3: begin y[dir_reg] = c_up(site_reg[dir_reg]); ydir = perp; end
            3'd4: begin y[perp] = c_up(site_reg[perp]); ydir = dir_reg; end
            default: ydir = perp;
        endcase
        rd_row = {rep_reg, y[0], y[1], y[2], y[3]};
    end

    // The 4-bit replica number is reduced modulo REPLICAS by repeated subtraction.
    logic [RW-1:0] rep_mod;
    always_comb
    begin
        logic [6:0] r;
        r = {3'b0, in_replica};
        for (int i = 0; i < 16; i++)
            if (r >= 7'(REPLICAS))
                r = r - 7'(REPLICAS);
        rep_mod = RW'(r);
    end

    // Decision logic.
    logic [2:0]        tidx;
    logic              plus;
    logic signed [AccW:0] acc_sum;
    logic signed [AccW-1:0] acc_sat;
    logic signed [3:0] delta;
    logic [ROWW-1:0]   wr_row;

    assign tidx  = 3'((sum_reg + 4'sd6) >>> 1);
    assign plus  = in_rnd_cmp(rnd_reg, thresh[tidx]);
    assign delta = plus ? sum_reg : -sum_reg;
    assign acc_sum = (sweep_reg ? '0 : {acc_reg[AccW-1], acc_reg})
                     + (AccW+1)'(delta);
    assign acc_sat = (acc_sum[AccW] != acc_sum[AccW-1])
                     ? {acc_sum[AccW], {(AccW-1){~acc_sum[AccW]}}}
                     : acc_sum[AccW-1:0];
    assign wr_row = {rep_reg, site_reg[0], site_reg[1], site_reg[2], site_reg[3]};

    // Memory: one write port, one read port, registered read data.
    logic [3:0] row_old_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.clear_go)
            mem[clr_reg] <= 4'b0;
        else if (cmd.decide)
            mem[wr_row] <= row_old_reg & ~(4'b1 << dir_reg) | ({3'b0, ~plus} << dir_reg);
        if (cmd.rd)
            rd_data_reg <= mem[rd_row];
        rd_lane_reg <= ydir;
    end

    // The own site row is read at a step where ydir names it; capture it
    // when the step reads the own site (sub five is U(s,p), own row).
    logic       own_pend_reg;
    always_ff @(posedge clk)
    begin
        own_pend_reg <= cmd.rd && (wr_row == rd_row);
        if (own_pend_reg)
            row_old_reg <= rd_data_reg;
    end

    assign stat.clear_done = clr_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            if (cmd.clear_go)
            begin
                clr_reg <= clr_reg + ROWW'(1);
                if (clr_reg == ROWW'(ROWS - 1))
                    clr_done_reg <= 1'b1;
            end
            if (cmd.decide)
                acc_reg <= acc_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rep_reg   <= rep_mod;
            for (int k = 0; k < 4; k++)
                site_reg[k] <= wrap_mod(in_coord[k]);
            dir_reg   <= in_dir;
            rnd_reg   <= in_rnd;
            sweep_reg <= in_sweep;
            sum_reg   <= '0;
            prod_reg  <= 1'b0;
        end
        else if (cmd.acc_link)
        begin
            // Each staple is three reads; the third closes the product.
            if (cmd.acc_step == 5'd2 || cmd.acc_step == 5'd5 ||
                cmd.acc_step == 5'd8 || cmd.acc_step == 5'd11 ||
                cmd.acc_step == 5'd14 || cmd.acc_step == 5'd17)
            begin
                sum_reg  <= (prod_reg ^ rd_data_reg[rd_lane_reg])
                            ? sum_reg - 4'sd1 : sum_reg + 4'sd1;
                prod_reg <= 1'b0;
            end
            else
                prod_reg <= prod_reg ^ rd_data_reg[rd_lane_reg];
        end
        if (cmd.decide)
        begin
            res_link   <= plus;
            res_staple <= sum_reg <<< 0;
            res_action <= acc_sat;
        end
    end

    a_sum_even: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> !sum_reg[0])
        else $error("odd staple sum");
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> (sum_reg >= -4'sd6 && sum_reg <= 4'sd6))
        else $error("staple sum out of range");
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> clr_done_reg)
        else $error("item taken before clear");
endmodule

### rtl/z2_gauge_heatbath_link_update.sv
// Top level of the Z2 heatbath link update: stream ports, APB register file,
// controller and datapath. Depends on z2hb_pkg, z2hb_ctrl, z2hb_datapath.
//
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tdata: replica, coords, direction, random
// m_axis    out  tvalid/tready        tdata: new_link, staple_sum, action_sum
// apb       in   psel/penable/pready  seven 32-bit thresholds at 4*i
//
// An item is accepted, then makes eighteen neighbor reads through the single
// link memory read port, waits for the last read data and ends with the
// decision and write-back. After reset a clearing pass writes every
// memory row, one row per cycle over the full replica and coordinate address
// range (65536 rows at the defaults), during which no item is taken.
// A held result stalls only the next decision, not acceptance.
`timescale 1ns / 1ps
module z2_gauge_heatbath_link_update #(
    parameter int unsigned LATTICE_SIDE = z2hb_pkg::LatticeSideDefault,
    parameter int unsigned REPLICAS     = z2hb_pkg::ReplicasDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // replica[3:0], coord_t[6:4], coord_x[9:7], coord_y[12:10],
    // coord_z[15:13], direction[17:16], random_fraction[49:18], zero fill
    input  logic [55:0] s_axis_tdata,
    // sweep_start
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // new_link[0], staple_sum[4:1], action_sum[22:5], zero fill
    output logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [z2hb_pkg::CfgAddrW-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import z2hb_pkg::*;

    logic [31:0] th_reg [7];
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        out_valid_reg;
    logic        res_link;
    logic signed [3:0]  res_staple;
    logic signed [17:0] res_action;
    logic [2:0]  coord_bus [4];
    logic        in_fire;

    assign pready = 1'b1;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
                th_reg[i] <= 32'h8000_0000;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                REG_TH_M6:   th_reg[0] <= pwdata;
                REG_TH_M4:   th_reg[1] <= pwdata;
                REG_TH_M2:   th_reg[2] <= pwdata;
                REG_TH_ZERO: th_reg[3] <= pwdata;
                REG_TH_P2:   th_reg[4] <= pwdata;
                REG_TH_P4:   th_reg[5] <= pwdata;
                REG_TH_P6:   th_reg[6] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_TH_M6:   prdata = th_reg[0];
            REG_TH_M4:   prdata = th_reg[1];
            REG_TH_M2:   prdata = th_reg[2];
            REG_TH_ZERO: prdata = th_reg[3];
            REG_TH_P2:   prdata = th_reg[4];
            REG_TH_P4:   prdata = th_reg[5];
            REG_TH_P6:   prdata = th_reg[6];
            default:     prdata = '0;
        endcase
    end

    assign coord_bus[0] = s_axis_tdata[6:4];
    assign coord_bus[1] = s_axis_tdata[9:7];
    assign coord_bus[2] = s_axis_tdata[12:10];
    assign coord_bus[3] = s_axis_tdata[15:13];

    z2hb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (!out_valid_reg || m_axis_tready),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    z2hb_datapath #(
        .LATTICE_SIDE (LATTICE_SIDE),
        .REPLICAS     (REPLICAS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_replica (s_axis_tdata[3:0]),
        .in_coord   (coord_bus),
        .in_dir     (s_axis_tdata[17:16]),
        .in_rnd     (s_axis_tdata[49:18]),
        .in_sweep   (s_axis_tuser),
        .thresh     (th_reg),
        .res_link   (res_link),
        .res_staple (res_staple),
        .res_action (res_action)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.decide)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_action, res_staple, res_link};
endmodule

### sim/testbench.sv
// Self-checking testbench for the Z2 heatbath link update block.
// Depends on z2hb_pkg and z2_gauge_heatbath_link_update; predicts every result in-line.
`timescale 1ns / 1ps
module testbench;
    import z2hb_pkg::*;

    localparam int unsigned SIDE      = 8;
    localparam int unsigned NREP      = 16;
    localparam int unsigned LINKS     = NREP * SIDE * SIDE * SIDE * SIDE * 4;
    localparam int          ACC_TOP   = 131071;
    localparam int          ACC_FLOOR = -131072;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic              new_link;
        logic signed [3:0] staple_sum;
        logic signed [17:0] action_sum;
    } link_result_t;

    localparam reg_addr_t THRESH_ADDR [NumThresh] = '{
        REG_TH_M6, REG_TH_M4, REG_TH_M2, REG_TH_ZERO, REG_TH_P2, REG_TH_P4, REG_TH_P6
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // replica[3:0], coord_t[6:4], coord_x[9:7], coord_y[12:10],
    // coord_z[15:13], direction[17:16], random_fraction[49:18], zero fill
    logic [55:0] s_axis_tdata;
    // sweep_start
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // new_link[0], staple_sum[4:1], action_sum[22:5], zero fill
    logic [23:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: a set bit marks a minus link.
    bit          minus_link [LINKS];
    logic [31:0] plus_threshold [NumThresh];
    int          action_total;
    link_result_t pending_results [$];

    int  failures;
    int  cycles;
    bit  idle_gaps;

    z2_gauge_heatbath_link_update i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic int link_index(int rep, int s [4], int dir);
        int a;
        a = rep;
        for (int k = 0; k < 4; k++)
        begin
            a = a * SIDE + (s[k] & (SIDE - 1));
        end
        return a * 4 + dir;
    endfunction

    function automatic int link_sign(int rep, int s [4], int dir);
        return minus_link[link_index(rep, s, dir)] ? -1 : 1;
    endfunction

    // Updates the lattice and the action exactly as the block does for one transfer.
    function automatic link_result_t heatbath_update(logic [3:0] rep, logic [2:0] c [4],
                                                     logic [1:0] dir, logic [31:0] rnd,
                                                     logic sweep);
        int site [4];
        int nb [4];
        int sum;
        int st;
        bit plus;
        link_result_t r;
        sum = 0;
        for (int k = 0; k < 4; k++)
        begin
            site[k] = int'(c[k]);
        end
        for (int p = 0; p < 4; p++)
        begin
            if (p != dir)
            begin
                nb = site;
                nb[p] = (nb[p] + SIDE - 1) % SIDE;
                st = link_sign(rep, nb, p) * link_sign(rep, nb, dir);
                nb[dir] = (nb[dir] + 1) % SIDE;
                st = st * link_sign(rep, nb, p);
                sum += st;
                nb = site;
                nb[dir] = (nb[dir] + 1) % SIDE;
                st = link_sign(rep, nb, p);
                nb = site;
                nb[p] = (nb[p] + 1) % SIDE;
                st = st * link_sign(rep, nb, dir) * link_sign(rep, site, p);
                sum += st;
            end
        end
        plus = rnd < plus_threshold[(sum + 6) / 2];
        minus_link[link_index(rep, site, dir)] = !plus;
        action_total = (sweep ? 0 : action_total) + (plus ? sum : -sum);
        if (action_total > ACC_TOP)
        begin
            action_total = ACC_TOP;
        end
        if (action_total < ACC_FLOOR)
        begin
            action_total = ACC_FLOOR;
        end
        r.new_link   = plus;
        r.staple_sum = 4'(sum);
        r.action_sum = 18'(action_total);
        return r;
    endfunction

    task automatic send_link(logic [3:0] rep, logic [2:0] c [4], logic [1:0] dir,
                             logic [31:0] rnd, logic sweep);
        int gap;
        gap = idle_gaps ? $urandom_range(4, 0) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, rnd, dir, c[3], c[2], c[1], c[0], rep};
        s_axis_tuser  <= sweep;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(heatbath_update(rep, c, dir, rnd, sweep));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
    endtask

    task automatic write_threshold(int idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESH_ADDR[idx];
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        plus_threshold[idx] = value;
        @(posedge clk);
    endtask

    // Coordinates cluster near the origin so that updated links meet again,
    // with the wrap-around edge included.
    function automatic logic [2:0] near_coord();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick < 3)
        begin
            return 3'd0;
        end
        else if (pick < 5)
        begin
            return 3'd1;
        end
        else if (pick < 7)
        begin
            return 3'd7;
        end
        return 3'($urandom_range(7, 0));
    endfunction

    task automatic send_random_link(bit clustered);
        logic [2:0]  c [4];
        logic [3:0]  rep;
        logic [31:0] rnd;
        for (int k = 0; k < 4; k++)
        begin
            c[k] = clustered ? near_coord() : 3'($urandom_range(7, 0));
        end
        rep = clustered ? (($urandom_range(1, 0) != 0) ? 4'd5 : 4'd10)
                        : 4'($urandom_range(15, 0));
        rnd = $urandom;
        send_link(rep, c, 2'($urandom_range(3, 0)), rnd, ($urandom_range(49, 0) == 0));
    endtask

    task automatic test_default_thresholds();
        logic [2:0] c [4];
        logic [31:0] rnds [4];
        rnds = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        for (int i = 0; i < 8; i++)
        begin
            c = '{3'(i[0] ? 7 : 0), 3'(i[1] ? 7 : 0), 3'(i[2] ? 7 : 0), 3'd0};
            send_link(i[0] ? 4'd15 : 4'd0, c, 2'(i % 4), rnds[i % 4], i == 0);
        end
        c = '{3'd7, 3'd7, 3'd7, 3'd7};
        for (int d = 0; d < 4; d++)
        begin
            send_link(4'd15, c, 2'(d), rnds[d], 1'b0);
        end
        wait_drained();
    endtask

    task automatic test_threshold_extremes();
        logic [2:0] c [4];
        for (int i = 0; i < NumThresh; i++)
        begin
            write_threshold(i, 32'h0);
        end
        // Every update now gives a minus link, which lowers the neighboring sums.
        for (int i = 0; i < 6; i++)
        begin
            c = '{3'd1, 3'd1, 3'd1, 3'(i % 2)};
            send_link(4'd3, c, 2'(i % 4), 32'h0, i == 0);
        end
        wait_drained();
        for (int i = 0; i < NumThresh; i++)
        begin
            write_threshold(i, 32'hFFFF_FFFF);
        end
        for (int i = 0; i < 6; i++)
        begin
            c = '{3'd1, 3'd1, 3'd1, 3'(i % 2)};
            send_link(4'd3, c, 2'(i % 4), (i < 3) ? 32'hFFFF_FFFE : 32'hFFFF_FFFF, 1'b0);
        end
        wait_drained();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++)
        begin
            for (int i = 0; i < NumThresh; i++)
            begin
                case (phase)
                    0: write_threshold(i, $urandom);
                    1: write_threshold(i, 32'h2000_0000 * (i + 1));
                    2: write_threshold(i, (i % 2) ? 32'hFFFF_FFFF : 32'h0);
                    default: write_threshold(i, $urandom_range(2, 0) == 0 ? 32'h8000_0000
                                                                          : $urandom);
                endcase
            end
            idle_gaps = (phase != 3);
            for (int n = 0; n < 250; n++)
            begin
                send_random_link($urandom_range(4, 0) != 0);
            end
            wait_drained();
        end
    endtask

    // Result side: random stalls per transfer, none while gaps are off.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_gaps ? $urandom_range(4, 0) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        link_result_t want;
        link_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[22:5]};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.new_link !== want.new_link)
                begin
                    $display("%0t: new_link expected %0d actual %0d",
                             $time, want.new_link, got.new_link);
                    failures++;
                end
                if (got.staple_sum !== want.staple_sum)
                begin
                    $display("%0t: staple_sum expected %0d actual %0d",
                             $time, want.staple_sum, got.staple_sum);
                    failures++;
                end
                if (got.action_sum !== want.action_sum)
                begin
                    $display("%0t: action_sum expected %0d actual %0d",
                             $time, want.action_sum, got.action_sum);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("z2_gauge_heatbath_link_update verification failed");
            $finish;
        end
    end

    initial
    begin
        failures      = 0;
        cycles        = 0;
        idle_gaps     = 1'b1;
        action_total  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        for (int i = 0; i < NumThresh; i++)
        begin
            plus_threshold[i] = 32'h8000_0000;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_thresholds();
        test_threshold_extremes();
        test_random_phases();
        if (failures == 0)
        begin
            $display("z2_gauge_heatbath_link_update verification clean");
        end
        else
        begin
            $display("z2_gauge_heatbath_link_update verification failed");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/z2hb_pkg.sv
rtl/z2hb_ctrl.sv
rtl/z2hb_datapath.sv
rtl/z2_gauge_heatbath_link_update.sv
sim/testbench.sv
